FILE: src/buddy_allocator_assert.svh
// Assertion macros for the buddy allocator.
// Each check is live in simulation and compiles away when SYNTH is defined.
`ifndef BUDDY_ALLOCATOR_ASSERT_SVH
`define BUDDY_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// Check that is switched off while reset is asserted.
`define BA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that also holds during reset.
`define BA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BA_ASSERT(lbl, prop, msg)
`define BA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/bud_pkg.sv
`timescale 1ns / 1ps

package bud_pkg;

    // Default sizing of the pool.
    localparam int POOL_PAGES_DEF = 8;
    localparam int PAGE_BYTES_DEF = 2048;
    localparam int MIN_BLOCK_DEF  = 16;
    localparam int ORDERS_DEF     = 8;

    // Fixed port widths.
    localparam int REQ_SIZE_W = 12;
    localparam int ADDR_W     = 14;
    localparam int HDR_W      = 7;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Reset value of the header size register.
    localparam logic [HDR_W-1:0] HDR_RESET = 7'd16;

    // Register index decoded from paddr[PADDR_W-1:2].
    localparam logic REG_IDX_HEADER = 1'b0;

    // Request codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_OOM       = 3'd2,
        ST_DOUBLE    = 3'd3,
        ST_IGNORED   = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SPLIT,
        S_FREE_TAG,
        S_MERGE_RD,
        S_MERGE_CHK
    } bud_state_t;

endpackage

FILE: src/bud_apb_regs.sv
`timescale 1ns / 1ps

module bud_apb_regs
    import bud_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [HDR_W-1:0]      header_bytes
);

    logic [HDR_W-1:0] header_reg;
    logic [HDR_W-1:0] header_next;
    logic             reg_idx;

    assign reg_idx = paddr[PADDR_W-1];
    assign pready  = 1'b1;

    // Write decode for the header size register.
    always_comb
    begin
        header_next = header_reg;
        if (psel && penable && pwrite && reg_idx == REG_IDX_HEADER)
        begin
            header_next = pwdata[HDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HDR_RESET;
        end
        else
        begin
            header_reg <= header_next;
        end
    end

    // Read mux; addresses past the register list read as zero.
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_IDX_HEADER)
        begin
            prdata = APB_DATA_W'(header_reg);
        end
    end

    assign header_bytes = header_reg;

endmodule

FILE: src/buddy_allocator.sv
`timescale 1ns / 1ps

// Channel      Signals                               Transaction
// request      start, busy, req_type, req_size,      start high while busy low
//              free_addr
// result       done, status, payload_addr            done high for one cycle
// config       psel, penable, pwrite, paddr,         write in access cycle
//              pwdata, prdata, pready
//
// After reset the block sweeps the tag memory, one entry per cycle, through all
// POOL_UNITS entries (1024 by default) with busy high.
// Allocate: accept, then a search over the blocks in the claimed pages (one tag
// memory read per cycle), a pick, then one split step per level and a final
// tag write. Free: accept, a tag check, then a read and a check for each buddy,
// or only the final write once the block has grown to a whole page.
// Errors found at accept return in the next cycle. The receiver cannot stall.

module buddy_allocator
    import bud_pkg::*;
#(
    parameter int POOL_PAGES = POOL_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int MIN_BLOCK  = MIN_BLOCK_DEF,
    parameter int ORDERS     = ORDERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [REQ_SIZE_W-1:0] req_size,
    input  logic [ADDR_W-1:0]     free_addr,
    output logic                  done,
    output logic [2:0]            status,
    output logic [ADDR_W-1:0]     payload_addr,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "buddy_allocator_assert.svh"

    localparam int POOL_UNITS = (POOL_PAGES * PAGE_BYTES) / MIN_BLOCK;
    localparam int PAGE_UNITS = PAGE_BYTES / MIN_BLOCK;
    localparam int UNIT_W     = (POOL_UNITS > 1) ? $clog2(POOL_UNITS) : 1;
    localparam int CNT_W      = UNIT_W + 1;
    localparam int ORD_W      = $clog2(ORDERS);
    localparam int TAG_W      = ORD_W + 2;
    localparam int TAG_S      = ORD_W + 1;
    localparam int TAG_A      = ORD_W;
    localparam int MIN_SH     = $clog2(MIN_BLOCK);
    localparam int PG_W       = $clog2(POOL_PAGES + 1);
    localparam int TOT_W      = REQ_SIZE_W + 1;

    localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(ORDERS - 1);

    logic [HDR_W-1:0] header_bytes;

    bud_state_t state_reg, state_next;

    logic [UNIT_W-1:0] clr_reg, clr_next;
    logic [PG_W-1:0]   pages_reg, pages_next;
    logic [CNT_W-1:0]  claimed_reg, claimed_next;
    logic [ORD_W-1:0]  k_reg, k_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [UNIT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              found_reg, found_next;
    logic [ORD_W-1:0]  best_ord_reg, best_ord_next;
    logic [UNIT_W-1:0] best_unit_reg, best_unit_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] payload_reg, payload_next;

    // Tag memory: one entry per minimum block, read data registered.
    logic [TAG_W-1:0]  tag_mem [POOL_UNITS];
    logic [TAG_W-1:0]  rdata_reg;
    logic              rd_en;
    logic [UNIT_W-1:0] rd_addr;
    logic              we;
    logic [UNIT_W-1:0] wa;
    logic [TAG_W-1:0]  wd;

    logic              accept;
    logic [TOT_W-1:0]  total;
    logic              too_large;
    logic [ORD_W-1:0]  k_calc;
    logic [ADDR_W-1:0] fa_off;
    logic [31:0]       fa_unit32;
    logic              bad_free;

    logic              t_start;
    logic              t_alloc;
    logic [ORD_W-1:0]  t_ord;
    logic              cand;
    logic [CNT_W-1:0]  scan_step;
    logic [CNT_W-1:0]  scan_nx;
    logic              scan_more;
    logic [UNIT_W-1:0] buddy;
    logic              buddy_match;
    logic [ADDR_W-1:0] alloc_addr;

    bud_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .header_bytes (header_bytes)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Request size plus header, rounded up to an order.
    always_comb
    begin
        int cnt;
        cnt       = 0;
        total     = TOT_W'(req_size) + TOT_W'(header_bytes);
        too_large = 32'(total) > 32'(PAGE_BYTES);
        for (int o = 0; o < ORDERS - 1; o++)
        begin
            if ((32'(MIN_BLOCK) << o) < 32'(total))
            begin
                cnt = cnt + 1;
            end
        end
        k_calc = ORD_W'(cnt);
    end

    // Free address checks made at accept time.
    always_comb
    begin
        fa_off    = free_addr - ADDR_W'(header_bytes);
        fa_unit32 = 32'(fa_off >> MIN_SH);
        bad_free  = (free_addr < ADDR_W'(header_bytes))
                 || ((fa_off & ADDR_W'(MIN_BLOCK - 1)) != '0)
                 || (fa_unit32 >= 32'(claimed_reg));
    end

    // Decode of the tag read last cycle.
    assign t_start   = rdata_reg[TAG_S];
    assign t_alloc   = rdata_reg[TAG_A];
    assign t_ord     = rdata_reg[ORD_W-1:0];
    assign cand      = t_start && !t_alloc && (t_ord >= k_reg)
                    && (!found_reg || (t_ord < best_ord_reg));
    assign scan_step = t_start ? (CNT_W'(1) << t_ord) : CNT_W'(1);
    assign scan_nx   = scan_reg + scan_step;
    assign scan_more = scan_nx < claimed_reg;
    assign buddy     = a_reg ^ (UNIT_W'(1) << ord_reg);
    assign buddy_match = t_start && !t_alloc && (t_ord == ord_reg);
    assign alloc_addr  = ADDR_W'({a_reg, {MIN_SH{1'b0}}}) + ADDR_W'(header_bytes);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == UNIT_W'(POOL_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_FREE)
                    begin
                        if (!bad_free)
                        begin
                            state_next = S_FREE_TAG;
                        end
                    end
                    else if (!too_large)
                    begin
                        state_next = (claimed_reg == '0) ? S_PICK : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!scan_more)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (found_reg || (pages_reg < PG_W'(POOL_PAGES)))
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SPLIT:
            begin
                if (ord_reg == k_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FREE_TAG:
            begin
                state_next = (t_start && t_alloc) ? S_MERGE_RD : S_IDLE;
            end
            S_MERGE_RD:
            begin
                state_next = (ord_reg == TOP_ORD) ? S_IDLE : S_MERGE_CHK;
            end
            S_MERGE_CHK:
            begin
                state_next = buddy_match ? S_MERGE_RD : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory port and result values.
    always_comb
    begin
        clr_next       = clr_reg;
        pages_next     = pages_reg;
        claimed_next   = claimed_reg;
        k_next         = k_reg;
        ord_next       = ord_reg;
        a_next         = a_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        best_ord_next  = best_ord_reg;
        best_unit_next = best_unit_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        payload_next   = payload_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        we             = 1'b0;
        wa             = a_reg;
        wd             = '0;
        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                clr_next = clr_reg + UNIT_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_FREE)
                    begin
                        if (bad_free)
                        begin
                            done_next    = 1'b1;
                            status_next  = ST_IGNORED;
                            payload_next = '0;
                        end
                        else
                        begin
                            a_next  = fa_unit32[UNIT_W-1:0];
                            rd_en   = 1'b1;
                            rd_addr = fa_unit32[UNIT_W-1:0];
                        end
                    end
                    else if (too_large)
                    begin
                        done_next    = 1'b1;
                        status_next  = ST_TOO_LARGE;
                        payload_next = '0;
                    end
                    else
                    begin
                        k_next     = k_calc;
                        found_next = 1'b0;
                        scan_next  = '0;
                        if (claimed_reg != '0)
                        begin
                            rd_en = 1'b1;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (cand)
                begin
                    found_next     = 1'b1;
                    best_ord_next  = t_ord;
                    best_unit_next = scan_reg[UNIT_W-1:0];
                end
                scan_next = scan_nx;
                if (scan_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = scan_nx[UNIT_W-1:0];
                end
            end
            S_PICK:
            begin
                if (found_reg)
                begin
                    a_next   = best_unit_reg;
                    ord_next = best_ord_reg;
                end
                else if (pages_reg < PG_W'(POOL_PAGES))
                begin
                    // Claim the next page as one free top-order block.
                    a_next       = claimed_reg[UNIT_W-1:0];
                    ord_next     = TOP_ORD;
                    pages_next   = pages_reg + PG_W'(1);
                    claimed_next = claimed_reg + CNT_W'(PAGE_UNITS);
                end
                else
                begin
                    done_next    = 1'b1;
                    status_next  = ST_OOM;
                    payload_next = '0;
                end
            end
            S_SPLIT:
            begin
                we = 1'b1;
                if (ord_reg != k_reg)
                begin
                    // Upper half becomes a free block one order down.
                    wa       = a_reg + (UNIT_W'(1) << (ord_reg - ORD_W'(1)));
                    wd       = {1'b1, 1'b0, ord_reg - ORD_W'(1)};
                    ord_next = ord_reg - ORD_W'(1);
                end
                else
                begin
                    wa           = a_reg;
                    wd           = {1'b1, 1'b1, k_reg};
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    payload_next = alloc_addr;
                end
            end
            S_FREE_TAG:
            begin
                if (!t_start)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_IGNORED;
                    payload_next = '0;
                end
                else if (!t_alloc)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_DOUBLE;
                    payload_next = '0;
                end
                else
                begin
                    ord_next = t_ord;
                end
            end
            S_MERGE_RD:
            begin
                if (ord_reg == TOP_ORD)
                begin
                    we           = 1'b1;
                    wa           = a_reg;
                    wd           = {1'b1, 1'b0, ord_reg};
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    payload_next = '0;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = buddy;
                end
            end
            S_MERGE_CHK:
            begin
                we = 1'b1;
                if (buddy_match)
                begin
                    // Drop the start tag of the upper block of the pair.
                    ord_next = ord_reg + ORD_W'(1);
                    if (buddy < a_reg)
                    begin
                        wa     = a_reg;
                        a_next = buddy;
                    end
                    else
                    begin
                        wa = buddy;
                    end
                end
                else
                begin
                    wa           = a_reg;
                    wd           = {1'b1, 1'b0, ord_reg};
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    payload_next = '0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pages_reg   <= '0;
            claimed_reg <= '0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pages_reg   <= pages_next;
            claimed_reg <= claimed_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        ord_reg       <= ord_next;
        a_reg         <= a_next;
        scan_reg      <= scan_next;
        best_ord_reg  <= best_ord_next;
        best_unit_reg <= best_unit_next;
        status_reg    <= status_next;
        payload_reg   <= payload_next;
    end

    // Tag memory ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tag_mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rdata_reg <= tag_mem[rd_addr];
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign payload_addr = payload_reg;

    // A read and a write never hit the same entry in one cycle.
    `BA_ASSERT(a_no_rw_clash, (we && rd_en) |-> (wa != rd_addr), "tag read and write collide")
    // The memory is untouched while the block waits for a request.
    `BA_ASSERT(a_idle_no_write, (state_reg == S_IDLE) |-> !we, "tag write while idle")
    // Failed requests report a zero payload address.
    `BA_ASSERT(a_err_zero_addr, (done && (status_reg != ST_OK)) |-> (payload_addr == '0),
        "error result with nonzero address")
    // A result is only produced by work that was in progress.
    `BA_ASSERT(a_done_after_work, done |-> ($past(busy) || $past(start)),
        "result without a request")
    // The page count never runs past the pool.
    `BA_ASSERT_ALWAYS(a_pages_bound, pages_reg <= PG_W'(POOL_PAGES), "page count overflow")

endmodule
